FILE: rtl/cba_pkg.sv
`timescale 1ns / 1ps
package cba_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 11;
  localparam int NUM_BLOCKS_W   = 9;
  localparam int BLOCK_SIZE_W   = 11;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_BLOCKS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = CFG_INDEX_W'(1);

  // Register reset values
  localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RST = NUM_BLOCKS_W'(8);
  localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = BLOCK_SIZE_W'(1);

  // Divider status towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/cba_div.sv
`timescale 1ns / 1ps
module cba_div #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_W        = 24,
  parameter int DIV_W        = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [ACC_W-1:0]        dividend_re,
  input  logic signed [ACC_W-1:0]        dividend_im,
  input  logic [DIV_W-1:0]               divisor,
  output logic signed [SAMPLE_WIDTH-1:0] quot_re,
  output logic signed [SAMPLE_WIDTH-1:0] quot_im,
  output cba_pkg::div_stat_t             stat
);
  import cba_pkg::*;

  localparam int MAG_W = ACC_W + 1;
  localparam int HI_W  = MAG_W - SAMPLE_WIDTH;
  localparam int CNT_W = $clog2(SAMPLE_WIDTH + 1);

  logic signed [ACC_W-1:0]        dvd      [2];
  logic signed [MAG_W-1:0]        ext      [2];
  logic [MAG_W-1:0]               mag      [2];
  logic [HI_W:0]                  trial    [2];
  logic                           ge       [2];
  logic [HI_W-1:0]                rem_r    [2];
  logic [HI_W-1:0]                rem_nxt  [2];
  logic [SAMPLE_WIDTH-1:0]        lo_r     [2];
  logic [SAMPLE_WIDTH-1:0]        lo_nxt   [2];
  logic                           neg_r    [2];
  logic [SAMPLE_WIDTH-1:0]        quot     [2];
  logic [HI_W:0]                  dvs_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           busy_r;
  logic                           done_r;

  assign dvd[0] = dividend_re;
  assign dvd[1] = dividend_im;

  // Restoring division on magnitudes, one quotient bit per lane per cycle.
  // The high part starts below the divisor since |sum| <= n * 2^(SAMPLE_WIDTH-1).
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ext[l]     = MAG_W'(dvd[l]);
      mag[l]     = ext[l][MAG_W-1] ? (~ext[l] + MAG_W'(1)) : ext[l];
      trial[l]   = {rem_r[l], lo_r[l][SAMPLE_WIDTH-1]};
      ge[l]      = (trial[l] >= dvs_r);
      rem_nxt[l] = ge[l] ? HI_W'(trial[l] - dvs_r) : trial[l][HI_W-1:0];
      lo_nxt[l]  = {lo_r[l][SAMPLE_WIDTH-2:0], ge[l]};
      quot[l]    = neg_r[l] ? (~lo_r[l] + SAMPLE_WIDTH'(1)) : lo_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(SAMPLE_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= (HI_W + 1)'(divisor);
      for (int l = 0; l < 2; l++) begin
        neg_r[l] <= ext[l][MAG_W-1];
        rem_r[l] <= mag[l][MAG_W-1:SAMPLE_WIDTH];
        lo_r[l]  <= mag[l][SAMPLE_WIDTH-1:0];
      end
    end else if (busy_r) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[l] <= rem_nxt[l];
        lo_r[l]  <= lo_nxt[l];
      end
    end
  end

  assign quot_re   = quot[0];
  assign quot_im   = quot[1];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/complex_block_averager.sv
`timescale 1ns / 1ps
// Coherent block averager for complex Q1.15 samples. The stream is cut into
// frames of num_blocks blocks of block_size samples; sample position n is
// summed across the blocks of a frame in a per-position accumulator memory
// (one word holds the real and imaginary sums), the first block overwriting
// and later blocks adding. During the last block each sample yields one
// result, the sum divided by num_blocks and truncated toward zero; the final
// result of the frame carries end_of_block. Each sample is one transaction
// through a read-modify-write of the accumulator memory: a sample that gives
// no result goes through the memory read, then add and write back. A sample
// of the last block then also goes through the shared bit-serial divider,
// which works both parts at one quotient bit per cycle, and then waits for
// the output register. Any write to a known register restarts the frame;
// accumulator contents are left as they are and are overwritten by the next
// first block. Write registers only while no transaction is in flight.
module complex_block_averager #(
  parameter int MAX_BLOCK    = 1024,
  parameter int MAX_AVERAGE  = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_im,
  // averaged output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_re,
  output logic signed [SAMPLE_WIDTH-1:0]      out_avg_im,
  output logic                                out_end_of_block,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cba_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cba_pkg::*;

  localparam int ACC_W  = SAMPLE_WIDTH + $clog2(MAX_AVERAGE);
  localparam int DIV_W  = $clog2(MAX_AVERAGE + 1);
  localparam int BS_W   = $clog2(MAX_BLOCK + 1);
  localparam int POS_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int BC_W   = (MAX_AVERAGE > 1) ? $clog2(MAX_AVERAGE) : 1;
  localparam int WORD_W = 2 * ACC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RMW  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [NUM_BLOCKS_W-1:0]        num_blocks_r;
  logic [BLOCK_SIZE_W-1:0]        block_size_r;
  logic [POS_W-1:0]               pos_r;
  logic [BC_W-1:0]                bc_r;

  logic [DIV_W-1:0]               nb_eff;
  logic [BS_W-1:0]                bs_eff;
  logic [POS_W-1:0]               bs_m1;
  logic [BC_W-1:0]                nb_m1;
  logic [POS_W-1:0]               pos_use;
  logic [BC_W-1:0]                bc_use;
  logic                           last_pos;
  logic                           last_blk;

  logic                           in_accept;
  logic                           cfg_we;

  // transaction captured at acceptance
  logic signed [SAMPLE_WIDTH-1:0] x_re_r, x_im_r;
  logic [POS_W-1:0]               addr_r;
  logic                           first_r;
  logic                           emit_r;
  logic                           eob_r;

  logic [WORD_W-1:0]              mem [MAX_BLOCK];
  logic [WORD_W-1:0]              rd_word_r;
  logic signed [ACC_W-1:0]        sum_re, sum_im;
  logic                           mem_we;

  logic                           div_start;
  div_stat_t                      div_stat;
  logic signed [SAMPLE_WIDTH-1:0] quot_re, quot_im;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] avg_re_r, avg_im_r;
  logic                           eob_out_r;
  logic                           load_out;

  // Effective register values: zero counts as one, saturate at the maxima
  always_comb begin
    if (num_blocks_r == '0) begin
      nb_eff = DIV_W'(1);
    end else if (32'(num_blocks_r) > 32'(MAX_AVERAGE)) begin
      nb_eff = DIV_W'(MAX_AVERAGE);
    end else begin
      nb_eff = DIV_W'(num_blocks_r);
    end
    if (block_size_r == '0) begin
      bs_eff = BS_W'(1);
    end else if (32'(block_size_r) > 32'(MAX_BLOCK)) begin
      bs_eff = BS_W'(MAX_BLOCK);
    end else begin
      bs_eff = BS_W'(block_size_r);
    end
  end

  assign bs_m1    = POS_W'(bs_eff - BS_W'(1));
  assign nb_m1    = BC_W'(nb_eff - DIV_W'(1));
  assign pos_use  = (pos_r > bs_m1) ? bs_m1 : pos_r;
  assign bc_use   = (bc_r > nb_m1) ? nb_m1 : bc_r;
  assign last_pos = (pos_use == bs_m1);
  assign last_blk = (bc_use == nb_m1);

  // One transaction at a time: hold off input until the current one retires
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready &&
                     (cfg_index == REG_NUM_BLOCKS || cfg_index == REG_BLOCK_SIZE);

  // Registers; any known write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r <= NUM_BLOCKS_RST;
      block_size_r <= BLOCK_SIZE_RST;
      pos_r        <= '0;
      bc_r         <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_BLOCKS) begin
        num_blocks_r <= cfg_data[NUM_BLOCKS_W-1:0];
      end else begin
        block_size_r <= cfg_data[BLOCK_SIZE_W-1:0];
      end
      pos_r <= '0;
      bc_r  <= '0;
    end else if (in_accept) begin
      // advance position; wrap the block count at the end of the frame
      if (last_pos) begin
        pos_r <= '0;
        bc_r  <= last_blk ? '0 : bc_use + BC_W'(1);
      end else begin
        pos_r <= pos_use + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_re_r  <= in_sample_re;
      x_im_r  <= in_sample_im;
      addr_r  <= pos_use;
      first_r <= (bc_use == '0);
      emit_r  <= last_blk;
      eob_r   <= last_pos;
    end
  end

  // Accumulator memory: read on acceptance, write back in the following cycle.
  // The next read cannot issue before the write, so no forwarding is needed.
  assign sum_re = first_r ? ACC_W'(x_re_r) : signed'(rd_word_r[WORD_W-1:ACC_W]) + ACC_W'(x_re_r);
  assign sum_im = first_r ? ACC_W'(x_im_r) : signed'(rd_word_r[ACC_W-1:0]) + ACC_W'(x_im_r);
  assign mem_we = (state_r == ST_RMW);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= {sum_re, sum_im};
    end
    if (in_accept) begin
      rd_word_r <= mem[pos_use];
    end
  end

  assign div_start = (state_r == ST_RMW) && emit_r;

  cba_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_W        (ACC_W),
    .DIV_W        (DIV_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .dividend_re (sum_re),
    .dividend_im (sum_im),
    .divisor     (nb_eff),
    .quot_re     (quot_re),
    .quot_im     (quot_im),
    .stat        (div_stat)
  );

  // Drop the quotient into the output register once it is free
  assign load_out = (state_r == ST_DIV) && div_stat.done && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        state_nxt = emit_r ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_re_r  <= quot_re;
      avg_im_r  <= quot_im;
      eob_out_r <= eob_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_avg_re       = avg_re_r;
  assign out_avg_im       = avg_im_r;
  assign out_end_of_block = eob_out_r;

  // Checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DIV)
    else $error("output raised outside divide completion");

  a_bc_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> bc_r <= nb_m1)
    else $error("block count beyond frame length");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> pos_r <= bs_m1)
    else $error("position beyond block length");

endmodule
